// File: rtl/bu2x_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bu2x_pkg: shared types and constants of the 2x bilinear upscaler
// Image limits, field widths and the job record passed from the front
// part to the back part.
// ----------------------------------------------------------------------------
package bu2x_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int PIXEL_BITS  = 8;

    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int EW_BITS     = COL_BITS + 1;
    localparam int CFG_BITS    = 11;
    localparam int COORD_BITS  = 11;

    localparam int JOB_DEPTH    = 4;
    localparam int JOB_PTR_BITS = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_BITS = JOB_PTR_BITS + 1;

    typedef logic [PIXEL_BITS-1:0] pix_t;

    // One source pixel, with every value it can produce already computed.
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                has_up;
        logic                has_left;
        pix_t                diag;
        pix_t                vert;
        pix_t                horz;
        pix_t                orig;
    } job_t;

endpackage

// File: rtl/bu2x_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bu2x_front: position tracking, line store and averaging
// Places each accepted pixel in the source image, reads the pixel above it
// from the line store and builds the job record in the cycle after.
// ----------------------------------------------------------------------------
module bu2x_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  bu2x_pkg::pix_t          pixel_value,
    input  logic                    frame_start,
    input  logic [bu2x_pkg::EW_BITS-1:0] eff_width,
    output logic                    job_valid,
    output bu2x_pkg::job_t          job
);
    import bu2x_pkg::*;

    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    pix_t                left_reg, upper_left_reg;

    logic                s1_valid_reg;
    pix_t                s1_pix_reg;
    logic [ROW_BITS-1:0] s1_row_reg;
    logic [COL_BITS-1:0] s1_col_reg;
    pix_t                above_reg;

    pix_t                line_mem [MAX_WIDTH];

    logic [ROW_BITS-1:0] row_start, row_cur, row_inc;
    logic [COL_BITS-1:0] col_start, col_cur;
    logic [EW_BITS-1:0]  col_plus;

    logic [PIXEL_BITS+1:0] sum4;
    logic [PIXEL_BITS:0]   sum_v, sum_h;

    // Position of the arriving pixel; a column left beyond a shrunken width
    // wraps to the next row first.
    always_comb
    begin
        row_start = frame_start ? '0 : row_reg;
        col_start = frame_start ? '0 : col_reg;
        if ({1'b0, col_start} >= eff_width)
        begin
            col_cur = '0;
            row_cur = (row_start == ROW_BITS'(MAX_HEIGHT - 1)) ? '0 : row_start + 1'b1;
        end
        else
        begin
            col_cur = col_start;
            row_cur = row_start;
        end
        row_inc  = (row_cur == ROW_BITS'(MAX_HEIGHT - 1)) ? '0 : row_cur + 1'b1;
        col_plus = {1'b0, col_cur} + 1'b1;
        if (col_plus >= eff_width)
        begin
            col_next = '0;
            row_next = row_inc;
        end
        else
        begin
            col_next = col_plus[COL_BITS-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            left_reg       <= '0;
            upper_left_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (s1_valid_reg)
            begin
                left_reg       <= s1_pix_reg;
                upper_left_reg <= above_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pixel_value;
            s1_row_reg <= row_cur;
            s1_col_reg <= col_cur;
        end
    end

    // The read sees the entry before this pixel overwrites it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            above_reg          <= line_mem[col_cur];
            line_mem[col_cur]  <= pixel_value;
        end
    end

    always_comb
    begin
        sum4 = {2'b00, upper_left_reg} + {2'b00, above_reg} + {2'b00, left_reg}
             + {2'b00, s1_pix_reg} + (PIXEL_BITS+2)'(2);
        sum_v = {1'b0, above_reg} + {1'b0, s1_pix_reg} + 1'b1;
        sum_h = {1'b0, left_reg} + {1'b0, s1_pix_reg} + 1'b1;

        job.row      = s1_row_reg;
        job.col      = s1_col_reg;
        job.has_up   = (s1_row_reg != '0);
        job.has_left = (s1_col_reg != '0);
        job.diag     = sum4[PIXEL_BITS+1:2];
        job.vert     = sum_v[PIXEL_BITS:1];
        job.horz     = sum_h[PIXEL_BITS:1];
        job.orig     = s1_pix_reg;
    end

    assign job_valid = s1_valid_reg;

endmodule

// File: rtl/bu2x_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bu2x_job_fifo: short job queue between front and back
// Show-ahead queue of job records with an occupancy count.
// ----------------------------------------------------------------------------
module bu2x_job_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  bu2x_pkg::job_t                    din,
    input  logic                              pop,
    output bu2x_pkg::job_t                    dout,
    output logic [bu2x_pkg::JOB_CNT_BITS-1:0] count
);
    import bu2x_pkg::*;

    job_t                    slots [JOB_DEPTH];
    logic [JOB_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [JOB_CNT_BITS-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= din;
    end

    assign dout  = slots[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: rtl/bu2x_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bu2x_back: result sequencer and output register
// Walks the applicable results of each job into the output register, one per
// cycle unless a full output register that is not popped holds it back.
// ----------------------------------------------------------------------------
module bu2x_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             job_ready,
    input  bu2x_pkg::job_t                   job_head,
    output logic                             job_take,
    input  logic                             pop,
    output logic                             empty,
    output logic [bu2x_pkg::COORD_BITS-1:0]  out_row,
    output logic [bu2x_pkg::COORD_BITS-1:0]  out_col,
    output bu2x_pkg::pix_t                   out_value,
    output logic                             last_of_run
);
    import bu2x_pkg::*;

    typedef enum logic [1:0] {
        PH_DIAG,
        PH_VERT,
        PH_HORZ,
        PH_ORIG
    } phase_t;

    job_t                  job_reg;
    logic                  busy_reg;
    phase_t                phase_reg, phase_after, phase_first;
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] row_reg, col_reg;
    pix_t                  value_reg;
    logic                  last_reg;

    logic                  emit, finish;
    logic [COORD_BITS-1:0] row_even, col_even, row_sel, col_sel;
    pix_t                  value_sel;

    always_comb
    begin
        emit     = busy_reg && (!out_valid_reg || pop);
        finish   = emit && (phase_reg == PH_ORIG);
        job_take = job_ready && (!busy_reg || finish);

        if (job_head.has_up && job_head.has_left)
            phase_first = PH_DIAG;
        else if (job_head.has_up)
            phase_first = PH_VERT;
        else if (job_head.has_left)
            phase_first = PH_HORZ;
        else
            phase_first = PH_ORIG;

        row_even = COORD_BITS'({job_reg.row, 1'b0});
        col_even = COORD_BITS'({job_reg.col, 1'b0});

        case (phase_reg)
            PH_DIAG:
            begin
                phase_after = PH_VERT;
                row_sel     = row_even - 1'b1;
                col_sel     = col_even - 1'b1;
                value_sel   = job_reg.diag;
            end
            PH_VERT:
            begin
                phase_after = job_reg.has_left ? PH_HORZ : PH_ORIG;
                row_sel     = row_even - 1'b1;
                col_sel     = col_even;
                value_sel   = job_reg.vert;
            end
            PH_HORZ:
            begin
                phase_after = PH_ORIG;
                row_sel     = row_even;
                col_sel     = col_even - 1'b1;
                value_sel   = job_reg.horz;
            end
            default:
            begin
                phase_after = PH_ORIG;
                row_sel     = row_even;
                col_sel     = col_even;
                value_sel   = job_reg.orig;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_ORIG;
            job_reg       <= '0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            value_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (job_take)
            begin
                busy_reg  <= 1'b1;
                job_reg   <= job_head;
                phase_reg <= phase_first;
            end
            else if (finish)
                busy_reg <= 1'b0;
            else if (emit)
                phase_reg <= phase_after;

            if (emit)
            begin
                out_valid_reg <= 1'b1;
                row_reg       <= row_sel;
                col_reg       <= col_sel;
                value_reg     <= value_sel;
                last_reg      <= (phase_reg == PH_ORIG);
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_row     = row_reg;
    assign out_col     = col_reg;
    assign out_value   = value_reg;
    assign last_of_run = last_reg;

endmodule

// File: rtl/bilinear_upscale_2x.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_upscale_2x: streaming 2x bilinear upscaler for 8-bit grey images
// Turns a raster stream of source pixels into the pixels of an image of
// (2R-1) x (2C-1), each tagged with its row and column.
// ----------------------------------------------------------------------------
// Usage. Source pixels enter through a queue-style port: an item is taken at
// a clock edge with push high and full low. frame_start on an item makes it
// source position (0,0). Results leave through a second queue-style port:
// while empty is low the oldest result sits on out_row, out_col, out_value
// and last_of_run, and pop takes it. Each source pixel yields one to four
// results, in the order diagonal, vertical, horizontal, original; the last
// one carries last_of_run.
// Throughput is one result per cycle while pop keeps up, so a pixel holds
// the sequencer in proportion to its results: four for an interior pixel,
// one for the first pixel of a frame. The result sequencer sets this rate;
// the line store read and the averaging are pipelined and never hold the
// input back. A taken pixel passes the averaging register, the job queue and
// the job register before its first result shows. A stalled receiver fills
// the output register, then the job queue, and full rises; nothing is lost.
// Reset clears position, neighbor pixels and queues and sets image_width
// to 1. The line store is not cleared; stale entries read for the first
// row are not used. image_width (address 0) is written over the APB port by
// the user only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module bilinear_upscale_2x (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input queue
    input  logic                            push,
    output logic                            full,
    input  bu2x_pkg::pix_t                  pixel_value,
    input  logic                            frame_start,
    // result queue
    input  logic                            pop,
    output logic                            empty,
    output logic [bu2x_pkg::COORD_BITS-1:0] out_row,
    output logic [bu2x_pkg::COORD_BITS-1:0] out_col,
    output bu2x_pkg::pix_t                  out_value,
    output logic                            last_of_run
);
    import bu2x_pkg::*;

    logic [CFG_BITS-1:0]     image_width_reg;
    logic [EW_BITS-1:0]      eff_width;
    logic                    cfg_write, width_sel;

    logic                    accept;
    logic                    job_valid;
    job_t                    job_new, job_head;
    logic                    job_take;
    logic [JOB_CNT_BITS-1:0] job_count;
    logic [JOB_CNT_BITS-1:0] job_claimed;

    // The register occupies the first word; the word above it reads as zero.
    assign width_sel = (paddr[2] == 1'b0);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = width_sel ? {{(32 - CFG_BITS){1'b0}}, image_width_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            image_width_reg <= CFG_BITS'(1);
        else if (cfg_write && width_sel)
            image_width_reg <= pwdata[CFG_BITS-1:0];
    end

    // A width of zero behaves as one column; a width beyond the line store
    // is clamped to its size.
    always_comb
    begin
        if (image_width_reg == '0)
            eff_width = EW_BITS'(1);
        else if ({{(32 - CFG_BITS){1'b0}}, image_width_reg} > 32'(MAX_WIDTH))
            eff_width = EW_BITS'(MAX_WIDTH);
        else
            eff_width = EW_BITS'(image_width_reg);
    end

    // The pixel in the averaging stage has a queue slot reserved for it.
    assign job_claimed = job_count + JOB_CNT_BITS'(job_valid);
    assign full        = (job_claimed >= JOB_CNT_BITS'(JOB_DEPTH));
    assign accept      = push && !full;

    bu2x_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel_value (pixel_value),
        .frame_start (frame_start),
        .eff_width   (eff_width),
        .job_valid   (job_valid),
        .job         (job_new)
    );

    bu2x_job_fifo u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_valid),
        .din   (job_new),
        .pop   (job_take),
        .dout  (job_head),
        .count (job_count)
    );

    bu2x_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_ready   (job_count != '0),
        .job_head    (job_head),
        .job_take    (job_take),
        .pop         (pop),
        .empty       (empty),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .last_of_run (last_of_run)
    );

endmodule

// File: tb/bu2x_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bu2x_checker: scoreboard for the 2x bilinear upscaler
// Watches the register port and both item queues, keeps its own copy of the
// line store and position, and checks every upscaled pixel field by field.
// ----------------------------------------------------------------------------
package bu2x_tb_pkg;

    localparam logic [2:0] ADDR_IMAGE_WIDTH = 3'd0;

endpackage

module bu2x_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    input  logic [31:0]                     prdata,
    input  logic                            pready,
    input  logic                            push,
    input  logic                            full,
    input  bu2x_pkg::pix_t                  pixel_value,
    input  logic                            frame_start,
    input  logic                            pop,
    input  logic                            empty,
    input  logic [bu2x_pkg::COORD_BITS-1:0] out_row,
    input  logic [bu2x_pkg::COORD_BITS-1:0] out_col,
    input  bu2x_pkg::pix_t                  out_value,
    input  logic                            last_of_run,
    output int                              mismatches,
    output int                              pending
);
    import bu2x_pkg::*;
    import bu2x_tb_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        pix_t                  value;
        logic                  last;
    } up_pix_t;

    up_pix_t               expected_pixels[$];
    up_pix_t               want;
    pix_t                  prev_line [MAX_WIDTH];
    pix_t                  left_pix;
    pix_t                  upper_left_pix;
    pix_t                  above_pix;
    logic [ROW_BITS-1:0]   src_row;
    logic [EW_BITS-1:0]    src_col;
    logic [EW_BITS-1:0]    eff_width;
    logic [CFG_BITS-1:0]   width_reg;
    logic [COORD_BITS-1:0] even_row;
    logic [COORD_BITS-1:0] even_col;
    logic [PIXEL_BITS+1:0] diag_sum;
    logic [PIXEL_BITS:0]   vert_sum;
    logic [PIXEL_BITS:0]   horz_sum;
    int                    errors;

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, want_v, got_v);
        end
    endtask

    task start_next_row();
        src_col = '0;
        src_row = (src_row == ROW_BITS'(MAX_HEIGHT - 1)) ? '0 : src_row + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pixels.delete();
            left_pix       = '0;
            upper_left_pix = '0;
            src_row        = '0;
            src_col        = '0;
            width_reg      = CFG_BITS'(1);
            errors         = 0;
            mismatches     <= 0;
            pending        <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == ADDR_IMAGE_WIDTH)
            begin
                if (pwrite)
                    width_reg = pwdata[CFG_BITS-1:0];
                else
                    check_field("image_width readback", 32'(width_reg), prdata);
            end

            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    $display("%0t: extra result, expected none, actual %0d/%0d/%0d/%0d",
                             $time, out_row, out_col, out_value, last_of_run);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("out_row", 32'(want.row), 32'(out_row));
                    check_field("out_col", 32'(want.col), 32'(out_col));
                    check_field("out_value", 32'(want.value), 32'(out_value));
                    check_field("last_of_run", 32'(want.last), 32'(last_of_run));
                end
            end

            if (push && !full)
            begin
                // Zero behaves as one, anything past the line store is clamped.
                if (width_reg == 0)
                    eff_width = EW_BITS'(1);
                else if (width_reg > MAX_WIDTH)
                    eff_width = EW_BITS'(MAX_WIDTH);
                else
                    eff_width = EW_BITS'(width_reg);

                if (frame_start)
                begin
                    src_row = '0;
                    src_col = '0;
                end
                if (src_col >= eff_width)
                    start_next_row();

                above_pix = prev_line[src_col[COL_BITS-1:0]];
                even_row  = {src_row, 1'b0};
                even_col  = {src_col[COL_BITS-1:0], 1'b0};
                diag_sum  = {2'b00, upper_left_pix} + {2'b00, above_pix}
                          + {2'b00, left_pix} + {2'b00, pixel_value}
                          + (PIXEL_BITS+2)'(2);
                vert_sum  = {1'b0, above_pix} + {1'b0, pixel_value} + 1'b1;
                horz_sum  = {1'b0, left_pix} + {1'b0, pixel_value} + 1'b1;

                if (src_row != 0 && src_col != 0)
                    expected_pixels.push_back('{row: even_row - 1'b1, col: even_col - 1'b1,
                                                value: diag_sum[PIXEL_BITS+1:2], last: 1'b0});
                if (src_row != 0)
                    expected_pixels.push_back('{row: even_row - 1'b1, col: even_col,
                                                value: vert_sum[PIXEL_BITS:1], last: 1'b0});
                if (src_col != 0)
                    expected_pixels.push_back('{row: even_row, col: even_col - 1'b1,
                                                value: horz_sum[PIXEL_BITS:1], last: 1'b0});
                expected_pixels.push_back('{row: even_row, col: even_col,
                                            value: pixel_value, last: 1'b1});

                prev_line[src_col[COL_BITS-1:0]] = pixel_value;
                upper_left_pix = above_pix;
                left_pix       = pixel_value;
                src_col        = src_col + 1'b1;
                if (src_col >= eff_width)
                    start_next_row();
            end

            mismatches <= errors;
            pending    <= expected_pixels.size();
        end
    end

endmodule

// File: tb/tb_bilinear_upscale_2x.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_upscale_2x: stimulus and verdict for the 2x bilinear upscaler
// Drives source pixels and register writes, drains results with random
// stalls, and leaves all prediction and comparison to the checker beside
// the block.
// ----------------------------------------------------------------------------
module tb_bilinear_upscale_2x;

    import bu2x_pkg::*;
    import bu2x_tb_pkg::*;

    localparam int MAX_GAP       = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_COUNT    = 230;

    // A 4x3 frame of extremes and near-extremes. Averages of 0 and 255 land
    // exactly on a half and must round up; 1 and 2 check the low end.
    localparam pix_t [0:11] EDGE_GRID = {8'd255, 8'd0,   8'd255, 8'd0,
                                         8'd0,   8'd255, 8'd0,   8'd255,
                                         8'd1,   8'd2,   8'd254, 8'd255};

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [2:0]            paddr       = '0;
    logic [31:0]           pwdata      = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  push        = 1'b0;
    logic                  full;
    pix_t                  pixel_value = '0;
    logic                  frame_start = 1'b0;
    logic                  pop         = 1'b0;
    logic                  empty;
    logic [COORD_BITS-1:0] out_row;
    logic [COORD_BITS-1:0] out_col;
    pix_t                  out_value;
    logic                  last_of_run;

    int mismatches;
    int pending;

    // Shared between the stimulus and the result drain. A nonzero hold request
    // makes the drain keep pop low for that many cycles.
    int rx_hold_cycles = 0;
    // Effective width the block runs with; a wider setting forces the next
    // item to open a new frame so that no line store entry is read unwritten.
    int cur_eff        = 1;
    int items_sent     = 0;
    bit force_start    = 1'b0;
    bit tx_burst       = 1'b0;
    bit rx_burst       = 1'b0;

    bilinear_upscale_2x dut (.*);

    bu2x_checker checker_i (.*);

    always #5 clk = ~clk;

    // Every so often a side switches between random gaps and back-to-back
    // items, so both long busy stretches and gaps at every phase occur.
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 31) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Extremes show up often enough to hit rounding at both ends.
    function automatic pix_t random_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one source pixel and returns at the edge where it is taken. push
    // is left high so that a back-to-back item needs only new data; any caller
    // that does not send again lowers push in the same step.
    task automatic send_pixel(input pix_t value, input logic start);
        int gap;
        gap = draw_gap(tx_burst);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        pixel_value <= value;
        frame_start <= start | force_start;
        force_start = 1'b0;
        do @(posedge clk); while (full);
        items_sent++;
    endtask

    // Stops offering items and waits until every predicted pixel has come
    // out, then lets the pipeline settle.
    task automatic wait_drained();
        int guard;
        guard = 0;
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes image_width while the block is idle and reads it straight back;
    // the checker compares the read data.
    task automatic set_width(input logic [31:0] data);
        int req;
        int new_eff;
        wait_drained();
        req     = int'(data[CFG_BITS-1:0]);
        new_eff = (req == 0) ? 1 : (req > MAX_WIDTH) ? MAX_WIDTH : req;
        if (new_eff > cur_eff)
            force_start = 1'b1;
        cur_eff = new_eff;

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_IMAGE_WIDTH;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // Back-to-back read: straight into its setup cycle.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: a random stall before each item, plus the long hold-off
    // when the stimulus asks for one. pop stays high across back-to-back items.
    initial
    begin : result_drain
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            gap = draw_gap(rx_burst);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin : stimulus
        int          n;
        int          h;
        int          k;
        logic [31:0] cfg;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Width out of reset is one, so every pixel is a row of its own and
        // the second pixel already averages with the line store.
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd1, 1'b0);

        // A small frame of extremes: every kind of result appears, including
        // the four-way diagonal average.
        set_width(32'd4);
        for (k = 0; k < 12; k++)
            send_pixel(EDGE_GRID[k], k == 0);

        // The width shrinks while the position sits past the new width in
        // the middle of a row: the next pixel must wrap to a new row first.
        for (k = 0; k < 7; k++)
            send_pixel(random_pixel(), k == 0);
        set_width(32'd2);
        for (k = 0; k < 3; k++)
            send_pixel(random_pixel(), 1'b0);

        // Width zero behaves as one: every pixel opens a row of its own.
        set_width(32'd0);
        for (k = 0; k < 6; k++)
            send_pixel(random_pixel(), k == 0);

        // All eleven width bits set: clamped to the line store size, so the
        // pixels stay on one row.
        set_width(32'h7FF);
        for (k = 0; k < 12; k++)
            send_pixel(random_pixel(), k == 0);

        // The receiver stops for a long stretch while pixels keep coming, so
        // the block fills up and has to hold full high.
        set_width(32'd5);
        rx_hold_cycles = HOLD_CYCLES;
        for (k = 0; k < 30; k++)
            send_pixel(random_pixel(), k == 0);

        // Random part: mostly whole frames at small widths, with stray frame
        // starts, frames cut short and now and then a narrower width mid-frame.
        // Upper data bits of each write are junk and must be dropped.
        while (items_sent < ITEM_COUNT)
        begin
            case ($urandom_range(0, 9))
                0:          cfg = 32'd0;
                1, 2, 3:    cfg = $urandom_range(1, 3);
                4, 5, 6, 7: cfg = $urandom_range(4, 10);
                default:    cfg = $urandom_range(11, 32);
            endcase
            cfg = cfg | ($urandom & ~32'h7FF);
            set_width(cfg);
            repeat ($urandom_range(1, 3))
            begin
                h = $urandom_range(1, 4);
                n = h * cur_eff;
                for (k = 0; k < n && items_sent < ITEM_COUNT; k++)
                begin
                    if (k == n / 2 && cur_eff > 1 && $urandom_range(0, 3) == 0)
                        set_width(32'($urandom_range(1, cur_eff - 1)));
                    send_pixel(random_pixel(), k == 0 || $urandom_range(0, 29) == 0);
                    if ($urandom_range(0, 39) == 0)
                        break;
                end
            end
        end

        wait_drained();
        if (mismatches == 0 && pending == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            if (pending != 0)
                $display("%0t: %0d predicted pixels never came out", $time, pending);
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin : watchdog
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
